// ===== hw/rtl/rk4_pkg.sv =====
// Shared types and constants of the RK4 particle pusher.
package rk4_pkg;

  // Fixed field widths
  localparam int DW    = 48;  // field, position and velocity words
  localparam int PW    = 58;  // Q40 stage position with headroom
  localparam int SW    = 51;  // weighted sum of four field samples
  localparam int QW    = 43;  // quotient of a sum by 1536
  localparam int TW    = 16;  // Q15 interpolation weight, up to one
  localparam int CW    = 39;  // structure bound registers
  localparam int NW    = 8;   // node counts
  localparam int GW    = 7;   // load node index
  localparam int IW    = 3;   // configuration register index
  localparam int QDEPTH = 4;  // request queue entries
  localparam int QPW   = 2;   // queue pointer width
  localparam int QCW   = 3;   // queue fill count width

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PUSH = 1'b1;

  // Configuration register indexes
  localparam logic [IW-1:0] CFG_NX_USED    = 3'd0;
  localparam logic [IW-1:0] CFG_NY_USED    = 3'd1;
  localparam logic [IW-1:0] CFG_STRUCT_SX  = 3'd2;
  localparam logic [IW-1:0] CFG_STRUCT_EX  = 3'd3;
  localparam logic [IW-1:0] CFG_BOTTOM_TOP = 3'd4;
  localparam logic [IW-1:0] CFG_TOP_BOTTOM = 3'd5;

  // Fates
  localparam logic [1:0] FATE_FLIGHT = 2'd0;
  localparam logic [1:0] FATE_END    = 2'd1;
  localparam logic [1:0] FATE_STOP   = 2'd2;

  // Queue entry: a kept load or a push
  typedef struct packed {
    logic                 push;
    logic [GW-1:0]        gx;
    logic [GW-1:0]        gy;
    logic signed [DW-1:0] f0;  // accel_x or pos_x
    logic signed [DW-1:0] f1;  // accel_y or pos_y
    logic signed [DW-1:0] f2;  // vel_x
    logic signed [DW-1:0] f3;  // vel_y
  } rk4_entry_t;

  // Configuration as the engine sees it, node counts already clamped
  typedef struct packed {
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [CW-1:0] sx;
    logic [CW-1:0] ex;
    logic [CW-1:0] bt;
    logic [CW-1:0] tb;
  } rk4_cfg_t;

endpackage

// ===== hw/rtl/rk4_if.sv =====
// Handshake channels of the RK4 particle pusher: request, result, configuration.
interface rk4_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [rk4_pkg::GW-1:0]        grid_x;
  logic [rk4_pkg::GW-1:0]        grid_y;
  logic signed [rk4_pkg::DW-1:0] accel_x;
  logic signed [rk4_pkg::DW-1:0] accel_y;
  logic signed [rk4_pkg::DW-1:0] pos_x;
  logic signed [rk4_pkg::DW-1:0] pos_y;
  logic signed [rk4_pkg::DW-1:0] vel_x;
  logic signed [rk4_pkg::DW-1:0] vel_y;
  modport source (output valid, req_type, grid_x, grid_y, accel_x, accel_y,
                  pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, req_type, grid_x, grid_y, accel_x, accel_y,
                pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rk4_res_if;
  logic                          valid;
  logic                          ready;
  logic signed [rk4_pkg::DW-1:0] new_pos_x;
  logic signed [rk4_pkg::DW-1:0] new_pos_y;
  logic signed [rk4_pkg::DW-1:0] new_vel_x;
  logic signed [rk4_pkg::DW-1:0] new_vel_y;
  logic [1:0]                    fate;
  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, fate,
                  input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, fate,
                output ready);
endinterface

interface rk4_cfg_if;
  logic                   valid;
  logic                   ready;
  logic [rk4_pkg::IW-1:0] index;
  logic [rk4_pkg::CW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rk4_particle_push_bilinear_field.sv =====
// A load request writes one grid node into the field store. A push request runs in
// the engine through the four RK4 stages: each stage places its point and finds its
// cell, reads the four corners on the single-port field store, and runs the two-level
// interpolation; a stage whose point lies off the grid skips the reads and the
// interpolation. The closing divisions by 1536 run in four digit-serial dividers, and
// the result is then saturated, classified and handed off. A four-entry request queue
// and a result register let new requests be taken while a push is under way and while
// a result waits. There is no clearing pass after reset.
module rk4_particle_push_bilinear_field #(
  parameter int NX_MAX = 128,
  parameter int NY_MAX = 128
) (
  input  logic       clk,
  input  logic       rst,
  rk4_req_if.sink    req,
  rk4_res_if.source  res,
  rk4_cfg_if.sink    cfg
);

  logic [rk4_pkg::NW-1:0] nx_r;
  logic [rk4_pkg::NW-1:0] ny_r;
  logic [rk4_pkg::CW-1:0] sx_r;
  logic [rk4_pkg::CW-1:0] ex_r;
  logic [rk4_pkg::CW-1:0] bt_r;
  logic [rk4_pkg::CW-1:0] tb_r;
  rk4_pkg::rk4_cfg_t      cfg_eff;
  rk4_pkg::rk4_entry_t    q_entry;
  logic                   q_valid;
  logic                   q_pop;

  // Configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      nx_r <= 8'd128;
      ny_r <= 8'd128;
      sx_r <= '0;
      ex_r <= '0;
      bt_r <= '0;
      tb_r <= 39'h7F_0000_0000;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        rk4_pkg::CFG_NX_USED:    nx_r <= cfg.data[rk4_pkg::NW-1:0];
        rk4_pkg::CFG_NY_USED:    ny_r <= cfg.data[rk4_pkg::NW-1:0];
        rk4_pkg::CFG_STRUCT_SX:  sx_r <= cfg.data;
        rk4_pkg::CFG_STRUCT_EX:  ex_r <= cfg.data;
        rk4_pkg::CFG_BOTTOM_TOP: bt_r <= cfg.data;
        rk4_pkg::CFG_TOP_BOTTOM: tb_r <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamp node counts to the store
  always_comb begin
    cfg_eff.nx = (nx_r < 8'd2) ? 8'd2 : ((32'(nx_r) > NX_MAX) ? 8'(NX_MAX) : nx_r);
    cfg_eff.ny = (ny_r < 8'd2) ? 8'd2 : ((32'(ny_r) > NY_MAX) ? 8'(NY_MAX) : ny_r);
    cfg_eff.sx = sx_r;
    cfg_eff.ex = ex_r;
    cfg_eff.bt = bt_r;
    cfg_eff.tb = tb_r;
  end

  rk4_front #(.NX_MAX(NX_MAX), .NY_MAX(NY_MAX)) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  rk4_back #(.NX_MAX(NX_MAX), .NY_MAX(NY_MAX)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg_r   (cfg_eff),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

// ===== hw/rtl/rk4_front.sv =====
// Request front end: accepts requests, drops loads outside the store, queues the rest.
module rk4_front #(
  parameter int NX_MAX = 128,
  parameter int NY_MAX = 128
) (
  input  logic                clk,
  input  logic                rst,
  rk4_req_if.sink             req,
  output rk4_pkg::rk4_entry_t q_entry,
  output logic                q_valid,
  input  logic                q_pop
);

  rk4_pkg::rk4_entry_t             entries [rk4_pkg::QDEPTH];
  logic [rk4_pkg::QPW-1:0]         wr_ptr;
  logic [rk4_pkg::QPW-1:0]         rd_ptr;
  logic [rk4_pkg::QCW-1:0]         count;
  logic                            keep;
  logic                            push_en;
  logic                            pop_en;

  // Classify: a load outside the store is accepted and dropped
  assign keep = (req.req_type == rk4_pkg::REQ_PUSH) ||
                ((32'(req.grid_x) < NX_MAX) && (32'(req.grid_y) < NY_MAX));
  assign req.ready = (count != rk4_pkg::QCW'(rk4_pkg::QDEPTH));
  assign push_en   = req.valid && req.ready && keep;
  assign q_valid   = (count != '0);
  assign pop_en    = q_pop && q_valid;
  assign q_entry   = entries[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) wr_ptr <= wr_ptr + rk4_pkg::QPW'(1);
      if (pop_en) rd_ptr <= rd_ptr + rk4_pkg::QPW'(1);
      count <= count + rk4_pkg::QCW'(push_en) - rk4_pkg::QCW'(pop_en);
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push_en) begin
      entries[wr_ptr].push <= req.req_type;
      entries[wr_ptr].gx   <= req.grid_x;
      entries[wr_ptr].gy   <= req.grid_y;
      if (req.req_type == rk4_pkg::REQ_PUSH) begin
        entries[wr_ptr].f0 <= req.pos_x;
        entries[wr_ptr].f1 <= req.pos_y;
      end else begin
        entries[wr_ptr].f0 <= req.accel_x;
        entries[wr_ptr].f1 <= req.accel_y;
      end
      entries[wr_ptr].f2 <= req.vel_x;
      entries[wr_ptr].f3 <= req.vel_y;
    end
  end

endmodule

// ===== hw/rtl/rk4_div1536.sv =====
// Floor division of a signed sum by 1536, eight quotient bits a cycle.
module rk4_div1536 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [rk4_pkg::SW-1:0] val,
  output logic                          busy,
  output logic signed [rk4_pkg::QW-1:0] quo
);

  logic [41:0] u;
  logic [43:0] biased;
  logic [47:0] num;
  logic [47:0] qacc;
  logic [1:0]  rem;
  logic [2:0]  step;
  logic [1:0]  rem_next;
  logic [7:0]  qbits;
  logic [2:0]  t;
  logic [1:0]  r;

  // Divide by 512 with a shift, then bias to make the remaining divide by 3 unsigned
  assign u      = val[rk4_pkg::SW-1:9];
  assign biased = {{2{u[41]}}, u} + (44'd3 << 41);

  // Eight restoring steps by 3
  always_comb begin
    r = rem;
    t = '0;
    for (int k = 7; k >= 0; k--) begin
      t = {r, num[40+k]};
      if (t >= 3'd3) begin
        qbits[k] = 1'b1;
        r = 2'(t - 3'd3);
      end else begin
        qbits[k] = 1'b0;
        r = t[1:0];
      end
    end
    rem_next = r;
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd5) busy <= 1'b0;
    end
  end

  // Shift numerator, collect quotient
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= {4'b0, biased};
      rem  <= '0;
      qacc <= '0;
    end else if (busy) begin
      num  <= num << 8;
      rem  <= rem_next;
      qacc <= {qacc[39:0], qbits};
    end
  end

  // Remove the bias
  assign quo = signed'(qacc[rk4_pkg::QW-1:0] - (43'd1 << 41));

endmodule

// ===== hw/rtl/rk4_back.sv =====
// Push engine: field store, four RK4 stages with bilinear sampling, final update and fate.
module rk4_back #(
  parameter int NX_MAX = 128,
  parameter int NY_MAX = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  rk4_pkg::rk4_cfg_t   cfg_r,
  input  rk4_pkg::rk4_entry_t q_entry,
  input  logic                q_valid,
  output logic                q_pop,
  rk4_res_if.source           res
);

  localparam int AW = $clog2(NX_MAX * NY_MAX);
  localparam int PW = rk4_pkg::PW;
  localparam int DW = rk4_pkg::DW;
  localparam int SW = rk4_pkg::SW;
  localparam int QW = rk4_pkg::QW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PT   = 4'd1;
  localparam logic [3:0] S_IDX  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_L1   = 4'd4;
  localparam logic [3:0] S_L2   = 4'd5;
  localparam logic [3:0] S_L3   = 4'd6;
  localparam logic [3:0] S_L4   = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state;
  logic [1:0] sk;
  logic [2:0] cnt;

  // Field store
  logic signed [DW-1:0] mem_x [NX_MAX * NY_MAX];
  logic signed [DW-1:0] mem_y [NX_MAX * NY_MAX];
  logic signed [DW-1:0] rdx;
  logic signed [DW-1:0] rdy;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [AW-1:0]        load_addr;
  logic [AW-1:0]        rd_addr;

  // Particle and stage state
  logic signed [PW-1:0] x40, y40, ptx, pty, ptx_c, pty_c;
  logic signed [DW-1:0] vx, vy;
  logic signed [PW-1:0] vxe, vye, hxe, hye, a1xs, a1ys, a2xs, a2ys;
  logic [AW-1:0]        base, base_c;
  logic [rk4_pkg::TW-1:0] tx, ty, tx_c, ty_c;
  logic [7:0]           ix, iy, ixc, iyc;
  logic signed [PW-1:0] limx, limy;
  logic                 on_grid;

  // Interpolation
  logic signed [DW-1:0] cx [4];
  logic signed [DW-1:0] cy [4];
  logic signed [65:0]   p0x, p1x, p0y, p1y, p2x, p2y;
  logic signed [DW-1:0] r0x, r1x, r0y, r1y;
  logic signed [DW-1:0] akx [4];
  logic signed [DW-1:0] aky [4];
  logic signed [16:0]   txs, tys;

  // Final update
  logic signed [SW-1:0] svx, svy, spx, spy;
  logic signed [QW-1:0] q2x, q2y, q1x, q1y;
  logic                 b0, b1, b2, b3, div_busy, div_start;
  logic signed [PW-1:0] nvsx, nvsy, npsx, npsy;
  logic signed [DW-1:0] npx, npy, nvx, nvy;
  logic signed [DW-1:0] endx, endy, sxe, exe, bte, tbe;
  logic [1:0]           fate_c;
  logic                 out_valid, out_free;

  function automatic logic signed [DW-1:0] sat48(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[DW-1:0];
    if (v < lo) return lo[DW-1:0];
    return v[DW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] ext(input logic signed [DW-1:0] v);
    return {{(PW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] exts(input logic signed [DW-1:0] v);
    return {{(SW-DW){v[DW-1]}}, v};
  endfunction

  // Store port: loads write, pushes read the four corners
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign mem_we    = q_pop && (q_entry.push == rk4_pkg::REQ_LOAD);
  assign load_addr = AW'(32'(q_entry.gx) * NY_MAX + 32'(q_entry.gy));
  always_comb begin
    case (cnt[1:0])
      2'd0:    rd_addr = base;
      2'd1:    rd_addr = base + AW'(NY_MAX);
      2'd2:    rd_addr = base + AW'(1);
      default: rd_addr = base + AW'(NY_MAX + 1);
    endcase
  end
  assign mem_addr = mem_we ? load_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[mem_addr] <= q_entry.f0;
      mem_y[mem_addr] <= q_entry.f1;
    end
    rdx <= mem_x[mem_addr];
    rdy <= mem_y[mem_addr];
  end

  // Stage sample point
  assign vxe  = ext(vx);
  assign vye  = ext(vy);
  assign hxe  = vxe >>> 1;
  assign hye  = vye >>> 1;
  assign a1xs = ext(akx[0]) >>> 10;
  assign a1ys = ext(aky[0]) >>> 10;
  assign a2xs = ext(akx[1]) >>> 9;
  assign a2ys = ext(aky[1]) >>> 9;
  always_comb begin
    case (sk)
      2'd0: begin
        ptx_c = x40;
        pty_c = y40;
      end
      2'd1: begin
        ptx_c = x40 + hxe;
        pty_c = y40 + hye;
      end
      2'd2: begin
        ptx_c = x40 + hxe + a1xs;
        pty_c = y40 + hye + a1ys;
      end
      default: begin
        ptx_c = x40 + vxe + a2xs;
        pty_c = y40 + vye + a2ys;
      end
    endcase
  end

  // Cell index and weights
  assign limx    = {{(PW-48){1'b0}}, cfg_r.nx - 8'd1, 40'd0};
  assign limy    = {{(PW-48){1'b0}}, cfg_r.ny - 8'd1, 40'd0};
  assign on_grid = !ptx[PW-1] && (ptx <= limx) && !pty[PW-1] && (pty <= limy);
  assign ix      = ptx[47:40];
  assign iy      = pty[47:40];
  always_comb begin
    if (ix > cfg_r.nx - 8'd2) begin
      ixc  = cfg_r.nx - 8'd2;
      tx_c = 16'h8000;
    end else begin
      ixc  = ix;
      tx_c = {1'b0, ptx[39:25]};
    end
    if (iy > cfg_r.ny - 8'd2) begin
      iyc  = cfg_r.ny - 8'd2;
      ty_c = 16'h8000;
    end else begin
      iyc  = iy;
      ty_c = {1'b0, pty[39:25]};
    end
  end
  assign base_c = AW'(32'(ixc) * NY_MAX + 32'(iyc));
  assign txs    = {1'b0, tx};
  assign tys    = {1'b0, ty};

  // Weighted sums and dividers
  assign svx = exts(akx[0]) + (exts(akx[1]) <<< 1) + (exts(akx[2]) <<< 1) + exts(akx[3]);
  assign svy = exts(aky[0]) + (exts(aky[1]) <<< 1) + (exts(aky[2]) <<< 1) + exts(aky[3]);
  assign spx = exts(akx[0]) + exts(akx[1]) + exts(akx[2]);
  assign spy = exts(aky[0]) + exts(aky[1]) + exts(aky[2]);
  assign div_start = (state == S_DIV) && (cnt == 3'd0);
  assign div_busy  = b0 || b1 || b2 || b3;

  rk4_div1536 u_div_vx (.clk(clk), .rst(rst), .start(div_start), .val(svx), .busy(b0),
                        .quo(q2x));
  rk4_div1536 u_div_vy (.clk(clk), .rst(rst), .start(div_start), .val(svy), .busy(b1),
                        .quo(q2y));
  rk4_div1536 u_div_px (.clk(clk), .rst(rst), .start(div_start), .val(spx), .busy(b2),
                        .quo(q1x));
  rk4_div1536 u_div_py (.clk(clk), .rst(rst), .start(div_start), .val(spy), .busy(b3),
                        .quo(q1y));

  assign nvsx = vxe + {{(PW-QW){q2x[QW-1]}}, q2x};
  assign nvsy = vye + {{(PW-QW){q2y[QW-1]}}, q2y};
  assign npsx = x40 + vxe + {{(PW-QW){q1x[QW-1]}}, q1x};
  assign npsy = y40 + vye + {{(PW-QW){q1y[QW-1]}}, q1y};

  // Fate from the saturated position
  assign endx = {8'd0, cfg_r.nx - 8'd1, 32'd0};
  assign endy = {8'd0, cfg_r.ny - 8'd1, 32'd0};
  assign sxe  = {9'd0, cfg_r.sx};
  assign exe  = {9'd0, cfg_r.ex};
  assign bte  = {9'd0, cfg_r.bt};
  assign tbe  = {9'd0, cfg_r.tb};
  always_comb begin
    if (npx >= endx)
      fate_c = rk4_pkg::FATE_END;
    else if (npx[DW-1] || npy[DW-1] || (npy > endy))
      fate_c = rk4_pkg::FATE_STOP;
    else if ((npx >= sxe) && (npx <= exe) && ((npy <= bte) || (npy >= tbe)))
      fate_c = rk4_pkg::FATE_STOP;
    else
      fate_c = rk4_pkg::FATE_FLIGHT;
  end

  assign out_free  = !out_valid || res.ready;
  assign res.valid = out_valid;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sk        <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_entry.push == rk4_pkg::REQ_PUSH) begin
            state <= S_PT;
            sk    <= '0;
          end
        end
        S_PT: state <= S_IDX;
        S_IDX: begin
          cnt <= '0;
          if (on_grid) state <= S_RD;
          else if (sk == 2'd3) state <= S_DIV;
          else begin
            sk    <= sk + 2'd1;
            state <= S_PT;
          end
        end
        S_RD: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) state <= S_L1;
        end
        S_L1: state <= S_L2;
        S_L2: state <= S_L3;
        S_L3: state <= S_L4;
        S_L4: begin
          cnt <= '0;
          if (sk == 2'd3) state <= S_DIV;
          else begin
            sk    <= sk + 2'd1;
            state <= S_PT;
          end
        end
        S_DIV: begin
          if (cnt == 3'd0) cnt <= 3'd1;
          else if (!div_busy) state <= S_FIN;
        end
        S_FIN: state <= S_OUT;
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x40 <= {{(PW-DW-8){q_entry.f0[DW-1]}}, q_entry.f0, 8'h00};
        y40 <= {{(PW-DW-8){q_entry.f1[DW-1]}}, q_entry.f1, 8'h00};
        vx  <= q_entry.f2;
        vy  <= q_entry.f3;
      end
      S_PT: begin
        ptx <= ptx_c;
        pty <= pty_c;
      end
      S_IDX: begin
        base <= base_c;
        tx   <= tx_c;
        ty   <= ty_c;
        if (!on_grid) begin
          akx[sk] <= '0;
          aky[sk] <= '0;
        end
      end
      S_RD: begin
        if (cnt != 3'd0) begin
          cx[2'(cnt - 3'd1)] <= rdx;
          cy[2'(cnt - 3'd1)] <= rdy;
        end
      end
      S_L1: begin
        p0x <= $signed({cx[1][DW-1], cx[1]} - {cx[0][DW-1], cx[0]}) * txs;
        p1x <= $signed({cx[3][DW-1], cx[3]} - {cx[2][DW-1], cx[2]}) * txs;
        p0y <= $signed({cy[1][DW-1], cy[1]} - {cy[0][DW-1], cy[0]}) * txs;
        p1y <= $signed({cy[3][DW-1], cy[3]} - {cy[2][DW-1], cy[2]}) * txs;
      end
      S_L2: begin
        r0x <= cx[0] + DW'(p0x >>> 15);
        r1x <= cx[2] + DW'(p1x >>> 15);
        r0y <= cy[0] + DW'(p0y >>> 15);
        r1y <= cy[2] + DW'(p1y >>> 15);
      end
      S_L3: begin
        p2x <= $signed({r1x[DW-1], r1x} - {r0x[DW-1], r0x}) * tys;
        p2y <= $signed({r1y[DW-1], r1y} - {r0y[DW-1], r0y}) * tys;
      end
      S_L4: begin
        akx[sk] <= r0x + DW'(p2x >>> 15);
        aky[sk] <= r0y + DW'(p2y >>> 15);
      end
      S_FIN: begin
        nvx <= sat48(nvsx);
        nvy <= sat48(nvsy);
        npx <= sat48(npsx >>> 8);
        npy <= sat48(npsy >>> 8);
      end
      S_OUT: begin
        if (out_free) begin
          res.new_pos_x <= npx;
          res.new_pos_y <= npy;
          res.new_vel_x <= nvx;
          res.new_vel_y <= nvy;
          res.fate      <= fate_c;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/rk4_chk.sv =====
// Port checker for the RK4 particle pusher, bound to the top level.
module rk4_chk (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_fate,
  input logic [47:0] res_new_pos_x
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_new_pos_x))
    else $error("stalled result dropped or changed");

  // No result straight out of reset
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Fate is one of the three outcomes
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_fate == rk4_pkg::FATE_FLIGHT || res_fate == rk4_pkg::FATE_END ||
                   res_fate == rk4_pkg::FATE_STOP))
    else $error("bad fate code");

  // Reaching the far end means a non-negative x
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_fate == rk4_pkg::FATE_END |-> !res_new_pos_x[47])
    else $error("far end with negative x");

endmodule

bind rk4_particle_push_bilinear_field rk4_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_fate      (res.fate),
  .res_new_pos_x (res.new_pos_x)
);
